>>> hdl/rpc_pkg.sv
// shared types, constants and arctangent table of the rectangular/polar converter
`default_nettype none

package rpc_pkg;

    localparam int D_W     = 24;
    localparam int ANG_W   = 18;
    localparam int XY_W    = 36;
    localparam int Z_W     = 26;
    localparam int ATAN_W  = 22;
    localparam int INV_W   = 29;
    localparam int Q_W     = 7;
    localparam int RECIP_SHIFT = 40;

    localparam logic [1:0] KIND_RECT  = 2'd0;
    localparam logic [1:0] KIND_POLAR = 2'd1;

    localparam logic [INV_W-1:0]        INV_GAIN_Q29  = 29'd326016437;
    localparam logic signed [INV_W:0]   INV_GAIN_S    = 30'sd326016437;
    localparam logic [D_W-1:0]          RECIP_FULL    = 24'd11930464;
    localparam logic [D_W-1:0]          FULL_TURN_U   = 24'd92160;
    localparam logic signed [ANG_W-1:0] FULL_TURN_S   = 18'sd92160;
    localparam logic signed [ANG_W-1:0] HALF_TURN_S   = 18'sd46080;
    localparam logic signed [Z_W-1:0]   HALF_TURN_Z   = 26'sd46080;
    localparam logic signed [Z_W-1:0]   QUARTER_Z     = 26'sd5898240;
    localparam logic signed [Z_W-1:0]   ROUND_Z       = 26'sd128;
    localparam logic signed [XY_W-1:0]  ROUND_XY      = 36'sd128;
    localparam logic signed [XY_W-1:0]  S24_MAX_XY    = 36'sd8388607;
    localparam logic signed [XY_W-1:0]  S24_MIN_XY    = -36'sd8388608;
    localparam logic [D_W-1:0]          S24_MAX_U     = 24'd8388607;

    typedef enum logic [1:0] {
        OP_BAD   = 2'd0,
        OP_RECT  = 2'd1,
        OP_POLAR = 2'd2
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic                    zero;
        logic signed [D_W-1:0]   echo_x;
        logic signed [D_W-1:0]   echo_y;
        logic signed [D_W-1:0]   mag;
        logic signed [ANG_W-1:0] ang;
    } side_t;

    typedef struct packed {
        logic                   vec;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        side_t                  side;
    } cordic_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [ATAN_W-1:0] atan_tab(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rpc_cordic_stage.sv
// one registered cordic micro-rotation, vectoring or rotation per transaction
`default_nettype none

module rpc_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire                      stage_valid,
    input  wire rpc_pkg::cordic_t    stage,
    output logic                     rotated_valid,
    output rpc_pkg::cordic_t         rotated
);

    logic                               valid_reg;
    rpc_pkg::cordic_t                   stage_reg;
    rpc_pkg::cordic_t                   stage_next;
    logic signed [rpc_pkg::XY_W-1:0]    dx;
    logic signed [rpc_pkg::XY_W-1:0]    dy;
    logic signed [rpc_pkg::Z_W-1:0]     at;
    logic                               rot_pos;

    always_comb
    begin
        dx = stage.y >>> SHIFT;
        dy = stage.x >>> SHIFT;
        at = $signed({{(rpc_pkg::Z_W - rpc_pkg::ATAN_W){1'b0}},
                      rpc_pkg::atan_tab(5'(SHIFT))});
        rot_pos = stage.vec ? stage.y[rpc_pkg::XY_W-1] : !stage.z[rpc_pkg::Z_W-1];
        stage_next = stage;
        if (rot_pos)
        begin
            stage_next.x = stage.x - dx;
            stage_next.y = stage.y + dy;
            stage_next.z = stage.z - at;
        end
        else
        begin
            stage_next.x = stage.x + dx;
            stage_next.y = stage.y - dy;
            stage_next.z = stage.z + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign rotated_valid = valid_reg;
    assign rotated       = stage_reg;

endmodule

`default_nettype wire

>>> hdl/rect_polar_converter_unit.sv
// top level of the pipelined cordic rectangular/polar converter
`default_nettype none

// Converts between rectangular and polar form, one transaction per cycle unless the output
// stalls. kind 0 takes x and y (Q15.8) and returns them with the saturated magnitude and atan2
// angle in 1/256 degree; kind 1 takes a magnitude and an angle, reduces the angle modulo 360
// degrees keeping its sign, and returns x and y with the magnitude and reduced angle; other
// kinds return zeros with bad_mode set. The pipeline has four input stages for capture, angle
// reduction, gain prescale and quadrant setup, one register per cordic micro-rotation, and two
// output stages for the gain multiply and rounding. The whole pipeline advances whenever the
// output register is empty or being taken, so throughput is one transaction per cycle.

module rect_polar_converter_unit #(
    parameter int CORDIC_STAGES = 20
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // first_value, second_value
    input  wire  [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata,   // x_coord, y_coord, magnitude, angle_deg
    output logic [0:0]  m_axis_tuser    // bad_mode
);

    localparam int D_W   = rpc_pkg::D_W;
    localparam int ANG_W = rpc_pkg::ANG_W;
    localparam int XY_W  = rpc_pkg::XY_W;
    localparam int Z_W   = rpc_pkg::Z_W;
    localparam int INV_W = rpc_pkg::INV_W;
    localparam int Q_W   = rpc_pkg::Q_W;
    localparam int XP_W  = 54;
    localparam int HALF_W = 17;
    localparam int PP_W  = HALF_W + INV_W;

    logic en;

    // input stage
    logic                   a_valid_reg;
    logic [1:0]             a_kind_reg;
    logic signed [D_W-1:0]  a_first_reg;
    logic signed [D_W-1:0]  a_second_reg;

    // reciprocal and gain multiply stage
    logic                   b_neg;
    logic [D_W-1:0]         b_abs;
    logic [2*D_W-1:0]       b_qprod;
    logic signed [XP_W-1:0] b_x0prod;
    logic                   b_valid_reg;
    logic [1:0]             b_kind_reg;
    logic signed [D_W-1:0]  b_first_reg;
    logic signed [D_W-1:0]  b_second_reg;
    logic                   b_neg_reg;
    logic [D_W-1:0]         b_abs_reg;
    logic [Q_W-1:0]         b_q_reg;
    logic signed [XP_W-1:0] b_x0prod_reg;

    // remainder stage
    logic [D_W-1:0]           c_qm;
    logic [D_W-1:0]           c_r0;
    logic [D_W-1:0]           c_r;
    logic signed [ANG_W-1:0]  c_rs;
    logic signed [XP_W-1:0]   c_x0sum;
    logic                     c_valid_reg;
    logic [1:0]               c_kind_reg;
    logic signed [D_W-1:0]    c_first_reg;
    logic signed [D_W-1:0]    c_second_reg;
    logic signed [ANG_W-1:0]  c_red_reg;
    logic signed [31:0]       c_x0_reg;

    // cordic entry stage
    logic signed [ANG_W-1:0]  d_th;
    logic signed [Z_W-1:0]    d_zt;
    logic signed [XY_W-1:0]   d_x0;
    logic signed [XY_W-1:0]   d_xa;
    logic signed [XY_W-1:0]   d_ya;
    rpc_pkg::cordic_t         d_stage_next;
    rpc_pkg::cordic_t         d_stage_reg;
    logic                     d_valid_reg;

    rpc_pkg::cordic_t         cordic_pipe  [0:CORDIC_STAGES];
    logic                     cordic_valid [0:CORDIC_STAGES];
    rpc_pkg::cordic_t         cr;

    // gain multiply and rounding stage
    logic [33:0]              e_xc;
    logic signed [Z_W-1:0]    e_zr;
    logic signed [XY_W-1:0]   e_xr;
    logic signed [XY_W-1:0]   e_yr;
    logic signed [ANG_W-1:0]  e_ang_next;
    logic signed [D_W-1:0]    e_x_next;
    logic signed [D_W-1:0]    e_y_next;
    logic                     e_valid_reg;
    rpc_pkg::side_t           e_side_reg;
    logic [PP_W-1:0]          e_plo_reg;
    logic [PP_W-1:0]          e_phi_reg;
    logic signed [ANG_W-1:0]  e_ang_reg;
    logic signed [D_W-1:0]    e_x_reg;
    logic signed [D_W-1:0]    e_y_reg;

    // output stage
    logic [63:0]              f_sum;
    logic [26:0]              f_m;
    logic [D_W-1:0]           f_mag;
    logic [95:0]              out_data_next;
    logic                     out_bad_next;
    logic                     out_valid_reg;
    logic [95:0]              out_data_reg;
    logic                     out_bad_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= s_axis_tvalid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            e_valid_reg   <= cordic_valid[CORDIC_STAGES];
            out_valid_reg <= e_valid_reg;
        end
    end

    always_comb
    begin
        b_neg    = a_second_reg[D_W-1];
        b_abs    = b_neg ? (~a_second_reg + 1'b1) : a_second_reg;
        b_qprod  = (2*D_W)'(b_abs) * (2*D_W)'(rpc_pkg::RECIP_FULL);
        b_x0prod = XP_W'(a_first_reg) * XP_W'(rpc_pkg::INV_GAIN_S);
    end

    always_comb
    begin
        c_qm    = D_W'(b_q_reg) * rpc_pkg::FULL_TURN_U;
        c_r0    = b_abs_reg - c_qm;
        c_r     = (c_r0 >= rpc_pkg::FULL_TURN_U) ? (c_r0 - rpc_pkg::FULL_TURN_U) : c_r0;
        c_rs    = $signed(c_r[ANG_W-1:0]);
        c_x0sum = b_x0prod_reg + XP_W'(64'sd1048576);
    end

    // quadrant pre-rotation and mode setup
    always_comb
    begin
        d_th = c_red_reg;
        if (c_red_reg > rpc_pkg::HALF_TURN_S)
        begin
            d_th = c_red_reg - rpc_pkg::FULL_TURN_S;
        end
        else if (c_red_reg < -rpc_pkg::HALF_TURN_S)
        begin
            d_th = c_red_reg + rpc_pkg::FULL_TURN_S;
        end
        d_zt = Z_W'(d_th) <<< 8;
        d_x0 = XY_W'(c_x0_reg);
        d_xa = XY_W'($signed({c_first_reg, 8'b0}));
        d_ya = XY_W'($signed({c_second_reg, 8'b0}));

        d_stage_next             = '0;
        d_stage_next.side.echo_x = c_first_reg;
        d_stage_next.side.echo_y = c_second_reg;
        d_stage_next.side.mag    = c_first_reg;
        d_stage_next.side.ang    = c_red_reg;
        d_stage_next.side.zero   = (c_first_reg == '0) && (c_second_reg == '0);
        case (c_kind_reg)
            rpc_pkg::KIND_RECT:
            begin
                d_stage_next.side.op = rpc_pkg::OP_RECT;
                d_stage_next.vec     = 1'b1;
                d_stage_next.x       = d_xa;
                d_stage_next.y       = d_ya;
                d_stage_next.z       = '0;
                if (d_xa < 0)
                begin
                    if (d_ya >= 0)
                    begin
                        d_stage_next.x = d_ya;
                        d_stage_next.y = -d_xa;
                        d_stage_next.z = rpc_pkg::QUARTER_Z;
                    end
                    else
                    begin
                        d_stage_next.x = -d_ya;
                        d_stage_next.y = d_xa;
                        d_stage_next.z = -rpc_pkg::QUARTER_Z;
                    end
                end
            end
            rpc_pkg::KIND_POLAR:
            begin
                d_stage_next.side.op = rpc_pkg::OP_POLAR;
                d_stage_next.vec     = 1'b0;
                d_stage_next.x       = d_x0;
                d_stage_next.y       = '0;
                d_stage_next.z       = d_zt;
                if (d_zt > rpc_pkg::QUARTER_Z)
                begin
                    d_stage_next.z = d_zt - rpc_pkg::QUARTER_Z;
                    d_stage_next.x = '0;
                    d_stage_next.y = d_x0;
                end
                else if (d_zt < -rpc_pkg::QUARTER_Z)
                begin
                    d_stage_next.z = d_zt + rpc_pkg::QUARTER_Z;
                    d_stage_next.x = '0;
                    d_stage_next.y = -d_x0;
                end
            end
            default:
            begin
                d_stage_next.side.op = rpc_pkg::OP_BAD;
            end
        endcase
    end

    assign cordic_pipe[0]  = d_stage_reg;
    assign cordic_valid[0] = d_valid_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        rpc_cordic_stage #(
            .SHIFT (g)
        ) u_stage (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .stage_valid   (cordic_valid[g]),
            .stage         (cordic_pipe[g]),
            .rotated_valid (cordic_valid[g+1]),
            .rotated       (cordic_pipe[g+1])
        );
    end

    assign cr = cordic_pipe[CORDIC_STAGES];

    always_comb
    begin
        e_xc = cr.x[XY_W-1] ? '0 : cr.x[33:0];
        e_zr = (cr.z + rpc_pkg::ROUND_Z) >>> 8;
        if (e_zr > rpc_pkg::HALF_TURN_Z)
        begin
            e_ang_next = rpc_pkg::HALF_TURN_S;
        end
        else if (e_zr < -rpc_pkg::HALF_TURN_Z)
        begin
            e_ang_next = -rpc_pkg::HALF_TURN_S;
        end
        else
        begin
            e_ang_next = e_zr[ANG_W-1:0];
        end
        e_xr = (cr.x + rpc_pkg::ROUND_XY) >>> 8;
        e_yr = (cr.y + rpc_pkg::ROUND_XY) >>> 8;
        if (e_xr > rpc_pkg::S24_MAX_XY)
        begin
            e_x_next = rpc_pkg::S24_MAX_XY[D_W-1:0];
        end
        else if (e_xr < rpc_pkg::S24_MIN_XY)
        begin
            e_x_next = rpc_pkg::S24_MIN_XY[D_W-1:0];
        end
        else
        begin
            e_x_next = e_xr[D_W-1:0];
        end
        if (e_yr > rpc_pkg::S24_MAX_XY)
        begin
            e_y_next = rpc_pkg::S24_MAX_XY[D_W-1:0];
        end
        else if (e_yr < rpc_pkg::S24_MIN_XY)
        begin
            e_y_next = rpc_pkg::S24_MIN_XY[D_W-1:0];
        end
        else
        begin
            e_y_next = e_yr[D_W-1:0];
        end
    end

    always_comb
    begin
        f_sum = 64'({e_phi_reg, {HALF_W{1'b0}}}) + 64'(e_plo_reg) + (64'd1 << 36);
        f_m   = f_sum[63:37];
        f_mag = (f_m > 27'(rpc_pkg::S24_MAX_U)) ? rpc_pkg::S24_MAX_U : f_m[D_W-1:0];

        out_data_next = '0;
        out_bad_next  = 1'b0;
        case (e_side_reg.op)
            rpc_pkg::OP_RECT:
            begin
                out_data_next[23:0]  = e_side_reg.echo_x;
                out_data_next[47:24] = e_side_reg.echo_y;
                out_data_next[71:48] = e_side_reg.zero ? '0 : f_mag;
                out_data_next[89:72] = e_side_reg.zero ? '0 : e_ang_reg;
            end
            rpc_pkg::OP_POLAR:
            begin
                out_data_next[23:0]  = e_x_reg;
                out_data_next[47:24] = e_y_reg;
                out_data_next[71:48] = e_side_reg.mag;
                out_data_next[89:72] = e_side_reg.ang;
            end
            default:
            begin
                out_bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_kind_reg   <= s_axis_tuser;
            a_first_reg  <= s_axis_tdata[23:0];
            a_second_reg <= s_axis_tdata[47:24];

            b_kind_reg   <= a_kind_reg;
            b_first_reg  <= a_first_reg;
            b_second_reg <= a_second_reg;
            b_neg_reg    <= b_neg;
            b_abs_reg    <= b_abs;
            b_q_reg      <= b_qprod[rpc_pkg::RECIP_SHIFT+Q_W-1:rpc_pkg::RECIP_SHIFT];
            b_x0prod_reg <= b_x0prod;

            c_kind_reg   <= b_kind_reg;
            c_first_reg  <= b_first_reg;
            c_second_reg <= b_second_reg;
            c_red_reg    <= b_neg_reg ? -c_rs : c_rs;
            c_x0_reg     <= c_x0sum[52:21];

            d_stage_reg  <= d_stage_next;

            e_side_reg   <= cr.side;
            e_plo_reg    <= PP_W'(e_xc[HALF_W-1:0]) * PP_W'(rpc_pkg::INV_GAIN_Q29);
            e_phi_reg    <= PP_W'(e_xc[33:HALF_W]) * PP_W'(rpc_pkg::INV_GAIN_Q29);
            e_ang_reg    <= e_ang_next;
            e_x_reg      <= e_x_next;
            e_y_reg      <= e_y_next;

            out_data_reg <= out_data_next;
            out_bad_reg  <= out_bad_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_bad_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("bad mode transaction carries nonzero data");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[89:72]) <= 18'sd92159) &&
                          ($signed(m_axis_tdata[89:72]) >= -18'sd92159))
        else $error("angle out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a held output");

endmodule

`default_nettype wire

>>> tb/rect_polar_converter_unit_tb.sv
// self-checking testbench of the rectangular/polar cordic converter
`timescale 1ns / 100ps

module rect_polar_converter_unit_tb;

    localparam int     STAGES        = 20;
    localparam int     PIPE_LATENCY  = STAGES + 6;
    localparam int     RANDOM_ITEMS  = 825;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     STALL_LIMIT   = 2000;
    localparam int     CALM_FROM     = 500;
    localparam int     CALM_TO       = 650;
    localparam longint TURN          = 92160;
    localparam longint HALF          = 46080;
    localparam longint QUARTER_Q16   = 5898240;
    localparam longint GAIN_INV      = 326016437;
    localparam longint OUT_MAX       = 8388607;
    localparam longint OUT_MIN       = -8388608;

    localparam logic [1:0] KIND_RSVD_A = 2'd2;
    localparam logic [1:0] KIND_RSVD_B = 2'd3;

    typedef struct packed {
        logic signed [rpc_pkg::D_W-1:0]   x_coord;
        logic signed [rpc_pkg::D_W-1:0]   y_coord;
        logic signed [rpc_pkg::D_W-1:0]   magnitude;
        logic signed [rpc_pkg::ANG_W-1:0] angle_deg;
        logic                             bad_mode;
    } conv_result_t;

    typedef struct packed {
        logic [1:0]                     kind;
        logic signed [rpc_pkg::D_W-1:0] first_value;
        logic signed [rpc_pkg::D_W-1:0] second_value;
        logic                           typed;
        conv_result_t                   want;
    } stim_row_t;

    localparam conv_result_t NO_RESULT = '0;
    localparam conv_result_t ALL_ZERO  = '0;
    localparam conv_result_t REJECTED  = '{24'sd0, 24'sd0, 24'sd0, 18'sd0, 1'b1};

    // atan(2^-i) in 2^-16 degree
    longint micro_angle [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    stim_row_t directed_rows [25] = '{
        '{KIND_RSVD_A,         24'sh7FFFFF, 24'sh800000, 1'b1, REJECTED},
        '{KIND_RSVD_B,         24'sh800000, 24'sh7FFFFF, 1'b1, REJECTED},
        '{rpc_pkg::KIND_RECT,  24'sd0,      24'sd0,      1'b1, ALL_ZERO},
        '{rpc_pkg::KIND_POLAR, 24'sd0,      24'sd0,      1'b1, ALL_ZERO},
        '{rpc_pkg::KIND_RECT,  24'sh7FFFFF, 24'sh7FFFFF, 1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  24'sh800000, 24'sh800000, 1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  24'sh800000, 24'sd0,      1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  -24'sd256,   24'sd0,      1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  24'sd0,      24'sd256,    1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  24'sd0,      -24'sd256,   1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  24'sh7FFFFF, 24'sd0,      1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  24'sd1,      24'sd0,      1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  -24'sd1,     -24'sd1,     1'b0, NO_RESULT},
        '{rpc_pkg::KIND_RECT,  24'sh7FFFFF, 24'sh800000, 1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sh7FFFFF, 24'sd0,      1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sh800000, 24'sd46080,  1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sd256,    24'sh7FFFFF, 1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sd256,    24'sh800000, 1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sd256,    24'sd92160,  1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sd256,    -24'sd92160, 1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sd256,    24'sd46081,  1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sd256,    -24'sd46081, 1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sd256,    24'sd23040,  1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, 24'sh7FFFFF, -24'sd23041, 1'b0, NO_RESULT},
        '{rpc_pkg::KIND_POLAR, -24'sd1,     24'sd12345,  1'b0, NO_RESULT}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    conv_result_t pending_conversions [$];
    int           n_taken    = 0;
    int           mismatches = 0;
    int           quiet_run  = 0;
    logic         held_off   = 1'b0;

    rect_polar_converter_unit #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_s24(input longint v);
        if (v > OUT_MAX)
            return OUT_MAX;
        if (v < OUT_MIN)
            return OUT_MIN;
        return v;
    endfunction

    function automatic conv_result_t convert_pair(input logic [1:0] k,
                                                  input logic signed [rpc_pkg::D_W-1:0] a_in,
                                                  input logic signed [rpc_pkg::D_W-1:0] b_in);
        conv_result_t    r;
        longint          a, b, x, y, z, t, dx, dy, red, x0;
        longint unsigned prod;
        int              i;
        r = '0;
        a = a_in;
        b = b_in;
        if (k == rpc_pkg::KIND_RECT)
        begin
            r.x_coord = a_in;
            r.y_coord = b_in;
            if (a != 0 || b != 0)
            begin
                x = a * 256;
                y = b * 256;
                z = 0;
                // pre-rotate the left half plane by a quarter turn
                if (x < 0)
                begin
                    t = x;
                    if (y >= 0)
                    begin
                        x = y;
                        y = -t;
                        z = QUARTER_Q16;
                    end
                    else
                    begin
                        x = -y;
                        y = t;
                        z = -QUARTER_Q16;
                    end
                end
                for (i = 0; i < STAGES && i < 32; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0)
                    begin
                        x += dx;
                        y -= dy;
                        z += micro_angle[i];
                    end
                    else
                    begin
                        x -= dx;
                        y += dy;
                        z -= micro_angle[i];
                    end
                end
                if (x < 0)
                    x = 0;
                prod = x;
                prod = (prod * GAIN_INV + (64'd1 << 36)) >> 37;
                r.magnitude = (prod > OUT_MAX) ? OUT_MAX[rpc_pkg::D_W-1:0]
                                               : prod[rpc_pkg::D_W-1:0];
                t = (z + 128) >>> 8;
                if (t > HALF)
                    t = HALF;
                if (t < -HALF)
                    t = -HALF;
                r.angle_deg = t[rpc_pkg::ANG_W-1:0];
            end
        end
        else if (k == rpc_pkg::KIND_POLAR)
        begin
            red = b % TURN;
            r.magnitude = a_in;
            r.angle_deg = red[rpc_pkg::ANG_W-1:0];
            t = red;
            if (t > HALF)
                t -= TURN;
            if (t < -HALF)
                t += TURN;
            z = t * 256;
            x0 = (a * 256 * GAIN_INV + (64'sd1 <<< 28)) >>> 29;
            x = x0;
            y = 0;
            if (z > QUARTER_Q16)
            begin
                z -= QUARTER_Q16;
                x = 0;
                y = x0;
            end
            else if (z < -QUARTER_Q16)
            begin
                z += QUARTER_Q16;
                x = 0;
                y = -x0;
            end
            for (i = 0; i < STAGES && i < 32; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= micro_angle[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += micro_angle[i];
                end
            end
            t = clamp_s24((x + 128) >>> 8);
            r.x_coord = t[rpc_pkg::D_W-1:0];
            t = clamp_s24((y + 128) >>> 8);
            r.y_coord = t[rpc_pkg::D_W-1:0];
        end
        else
        begin
            r.bad_mode = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [rpc_pkg::D_W-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return r[rpc_pkg::D_W-1:0];
            6, 7, 8:          return $signed(r[rpc_pkg::D_W-1:0]) >>> $urandom_range(22, 4);
            default:
            begin
                case (r[2:0])
                    3'd0:    return 24'sh7FFFFF;
                    3'd1:    return 24'sh800000;
                    3'd2:    return 24'sd0;
                    3'd3:    return 24'sd1;
                    3'd4:    return -24'sd1;
                    default: return 24'(256 * (int'(r[10:3]) - 128));
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [rpc_pkg::D_W-1:0] rand_angle();
        case ($urandom_range(9))
            0, 1, 2: return 24'($urandom());
            3, 4, 5: return 24'(int'($urandom_range(368640)) - 184320);
            6:       return 24'(int'($urandom_range(2)) * 92160 - 92160
                            + int'($urandom_range(46081)) * (($urandom_range(1) == 0) ? 1 : -1));
            default: return 24'(11520 * int'($urandom_range(32)) - 184320
                            + int'($urandom_range(4)) - 2);
        endcase
    endfunction

    task automatic offer(input logic [1:0] k, input logic signed [rpc_pkg::D_W-1:0] a,
                         input logic signed [rpc_pkg::D_W-1:0] b, input conv_result_t want);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= k;
        s_axis_tdata  <= {b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_conversions.push_back(want);
        n_taken++;
    endtask

    task automatic sender_gap();
        if (n_taken < CALM_FROM || n_taken >= CALM_TO)
            while ($urandom_range(99) < 20)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
    endtask

    task automatic check_field(input string what, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    initial
    begin : stimulus
        int                             n;
        logic [1:0]                     k;
        logic signed [rpc_pkg::D_W-1:0] a, b;
        logic [4:0]                     pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[j])
        begin
            offer(directed_rows[j].kind, directed_rows[j].first_value,
                  directed_rows[j].second_value,
                  directed_rows[j].typed ? directed_rows[j].want
                      : convert_pair(directed_rows[j].kind, directed_rows[j].first_value,
                                     directed_rows[j].second_value));
            sender_gap();
        end
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = 5'($urandom_range(19));
            if (pick < 9)
                k = rpc_pkg::KIND_RECT;
            else if (pick < 18)
                k = rpc_pkg::KIND_POLAR;
            else if (pick == 18)
                k = KIND_RSVD_A;
            else
                k = KIND_RSVD_B;
            a = rand_coord();
            b = (k == rpc_pkg::KIND_POLAR) ? rand_angle() : rand_coord();
            offer(k, a, b, convert_pair(k, a, b));
            if (n == 200)
            begin
                // let the pipeline drain completely
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_conversions.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                sender_gap();
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_conversions.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : receiver
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!held_off && n_taken >= 300)
            begin
                // long back-pressure so the pipeline fills and stalls its input
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            else if (n_taken >= CALM_FROM && n_taken < CALM_TO)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= 20);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        conv_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_conversions.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected transaction: expected none, got %h / %b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_conversions.pop_front();
                check_field("x_coord", want.x_coord, $signed(m_axis_tdata[23:0]));
                check_field("y_coord", want.y_coord, $signed(m_axis_tdata[47:24]));
                check_field("magnitude", want.magnitude, $signed(m_axis_tdata[71:48]));
                check_field("angle_deg", want.angle_deg, $signed(m_axis_tdata[89:72]));
                check_field("bad_mode", want.bad_mode, m_axis_tuser[0]);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_run = 0;
            else
                quiet_run++;
            if (quiet_run >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

>>> sim.f
hdl/rpc_pkg.sv
hdl/rpc_cordic_stage.sv
hdl/rect_polar_converter_unit.sv
tb/rect_polar_converter_unit_tb.sv
